/* rtl/core/ile_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 7;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] OP_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_TAIL   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_AT     = 3'd3;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [VALUE_W-1:0] READ_MISS_VALUE = '1;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_READ,
        ACT_INS,
        ACT_DEL
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic decide;
        logic rd_pos;
        logic rd_shift;
        logic wr_shift;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic need_shift;
        logic more;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/core/indexed_list_engine_core.sv */
// Flow: read and rejected requests go from decide straight to the result;
// insert/delete first move N elements (each move is a read then a write),
// then commit. One word in flight: a new word is taken only after the result
// of the last one is loaded, which waits while the output register is full.
// Reset: synchronous, active low; clears length and handshake state only,
// element memory keeps its contents and is undefined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine_core
// Ordered list of signed words with read, insert and delete by position.
// ----------------------------------------------------------------------------
module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // func[2:0], position[9:3], value[41:10]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // read_value[31:0], status[33:32], length[40:34]
);

    cmd_t cmd;
    sts_t sts;

    ile_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ile_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire

/* rtl/core/ile_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ile_ctrl
// Sequencer: accept a word, decide, walk the shift loop, commit, emit result.
// ----------------------------------------------------------------------------
module ile_ctrl
    import ile_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EXEC;
            end
            S_EXEC: begin
                case (sts.act)
                    ACT_INS, ACT_DEL: begin
                        state_next = sts.need_shift ? S_SHIFT_RD : S_COMMIT;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                state_next = sts.more ? S_SHIFT_RD : S_COMMIT;
            end
            S_COMMIT: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            S_EXEC: begin
                cmd.decide = 1'b1;
                cmd.rd_pos = (sts.act == ACT_READ);
            end
            S_SHIFT_RD: begin
                cmd.rd_shift = 1'b1;
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
            end
            S_FINISH: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/ile_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ile_dpath
// Element memory, length counter, shift index and result register.
// ----------------------------------------------------------------------------
module ile_dpath
    import ile_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // func, position, value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,  // read_value, status, length
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned OUT_USED = VALUE_W + STATUS_W + LEN_W;

    logic [VALUE_W-1:0] elem_mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    logic [CW-1:0]       count_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       at_reg;
    logic                del_reg;
    act_t                act_reg;
    logic [STATUS_W-1:0] st_reg;

    logic                 out_valid_reg;
    logic [OUT_USED-1:0]  out_data_reg;

    logic [CMPW-1:0]     pos_ext;
    logic [CMPW-1:0]     cnt_ext;
    logic [CMPW-1:0]     at_ext;
    act_t                act;
    logic [STATUS_W-1:0] st;
    logic                need_shift;
    logic [CW-1:0]       src_idx;
    logic                more;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [VALUE_W-1:0]  res_value;

    assign pos_ext = CMPW'(pos_reg);
    assign cnt_ext = CMPW'(count_reg);

    always_comb begin
        act        = ACT_NONE;
        st         = ST_RANGE;
        need_shift = 1'b0;
        at_ext     = pos_ext;
        case (func_reg)
            OP_READ: begin
                if (pos_ext < cnt_ext) begin
                    act = ACT_READ;
                    st  = ST_DONE;
                end
            end
            OP_HEAD, OP_TAIL, OP_AT: begin
                if (func_reg == OP_HEAD) begin
                    at_ext = '0;
                end else if (func_reg == OP_TAIL) begin
                    at_ext = cnt_ext;
                end
                if (at_ext > cnt_ext) begin
                    st = ST_RANGE;
                end else if (cnt_ext >= CMPW'(CAPACITY)) begin
                    st = ST_FULL;
                end else begin
                    act        = ACT_INS;
                    st         = ST_DONE;
                    need_shift = (cnt_ext > at_ext);
                end
            end
            OP_DELETE: begin
                if (pos_ext < cnt_ext) begin
                    act        = ACT_DEL;
                    st         = ST_DONE;
                    need_shift = ((CMPW + 1)'(pos_ext) + (CMPW + 1)'(1))
                                 < (CMPW + 1)'(cnt_ext);
                end
            end
            default: begin
                act = ACT_NONE;
                st  = ST_RANGE;
            end
        endcase
    end

    assign src_idx = del_reg ? (idx_reg + CW'(1)) : (idx_reg - CW'(1));
    assign more    = del_reg
        ? (((CW + 1)'(idx_reg) + (CW + 1)'(2)) < (CW + 1)'(count_reg))
        : ((CW + 1)'(idx_reg) > ((CW + 1)'(at_reg) + (CW + 1)'(1)));

    assign sts.act        = act;
    assign sts.need_shift = need_shift;
    assign sts.more       = more;
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            func_reg <= s_tdata[FUNC_W-1:0];
            pos_reg  <= s_tdata[FUNC_W +: POS_W];
            val_reg  <= s_tdata[FUNC_W + POS_W +: VALUE_W];
        end
        if (cmd.decide) begin
            act_reg <= act;
            st_reg  <= st;
            del_reg <= (act == ACT_DEL);
            at_reg  <= CW'(at_ext);
            idx_reg <= (act == ACT_INS) ? count_reg : CW'(pos_ext);
        end else if (cmd.wr_shift) begin
            idx_reg <= src_idx;
        end
    end

    // element memory: one write port, one registered read port
    assign mem_we    = cmd.wr_shift || (cmd.commit && act_reg == ACT_INS);
    assign mem_waddr = cmd.wr_shift ? AW'(idx_reg) : AW'(at_reg);
    assign mem_wdata = cmd.wr_shift ? rdata_reg : val_reg;
    assign mem_re    = cmd.rd_pos || cmd.rd_shift;
    assign mem_raddr = cmd.rd_shift ? AW'(src_idx) : AW'(pos_ext);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            elem_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= elem_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            if (act_reg == ACT_INS) begin
                count_reg <= count_reg + CW'(1);
            end else if (act_reg == ACT_DEL) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_comb begin
        if (act_reg == ACT_READ) begin
            res_value = rdata_reg;
        end else if (func_reg == OP_READ) begin
            res_value = READ_MISS_VALUE;
        end else begin
            res_value = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {LEN_W'(CMPW'(count_reg)), st_reg, res_value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed list engine core.
// Requests are queued by a stimulus process and driven in bursts with random
// gaps. Every accepted request runs through a shadow list model that predicts
// the reply word. Replies are taken under a rotating back-pressure pattern and
// compared field by field, in order. The stimulus alternates fill, drain and
// mixed phases so that the list regularly runs full and empty.
// ----------------------------------------------------------------------------
module tb;
    import ile_pkg::*;

    localparam int unsigned HALF_PERIOD  = 4;
    localparam int unsigned ITEM_TARGET  = 1550;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned END_CUSHION  = 2 * CAPACITY_DEF + 16;
    localparam int unsigned DRAIN_EVERY  = 500;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned S_PAD_W      = S_TDATA_W - FUNC_W - POS_W - VALUE_W;

    localparam logic [FUNC_W-1:0] OP_SPARE_LO = OP_DELETE + 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LAST   = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } list_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  rd;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    len;
    } list_reply_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } mix_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    list_req_t   request_q[$];
    list_reply_t reply_q[$];

    logic [VALUE_W-1:0] shadow_mem [CAPACITY_DEF];
    int unsigned        shadow_len = 0;

    int unsigned n_queued   = 0;
    int unsigned n_replies  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_done     = 0;
    int unsigned n_range    = 0;
    int unsigned n_full     = 0;
    int unsigned peak_len   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    logic [15:0] ready_pat = '1;
    logic [7:0]  pat_age   = '0;

    indexed_list_engine_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // shadow list: insert shifts up, delete shifts down
    task automatic apply_list_request(input list_req_t rq, output list_reply_t rs);
        int unsigned slot;
        rs.rd     = '0;
        rs.status = ST_DONE;
        case (rq.func)
            OP_READ: begin
                if (rq.pos < shadow_len) begin
                    rs.rd = shadow_mem[rq.pos];
                end else begin
                    rs.rd     = READ_MISS_VALUE;
                    rs.status = ST_RANGE;
                end
            end
            OP_HEAD, OP_TAIL, OP_AT: begin
                slot = (rq.func == OP_HEAD) ? 0 : (rq.func == OP_TAIL) ? shadow_len : rq.pos;
                if (slot > shadow_len) begin
                    rs.status = ST_RANGE;
                end else if (shadow_len >= CAPACITY_DEF) begin
                    rs.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i > slot; i--)
                        shadow_mem[i] = shadow_mem[i-1];
                    shadow_mem[slot] = rq.value;
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (rq.pos < shadow_len) begin
                    for (int i = rq.pos; i + 1 < shadow_len; i++)
                        shadow_mem[i] = shadow_mem[i+1];
                    shadow_len--;
                end else begin
                    rs.status = ST_RANGE;
                end
            end
            default: rs.status = ST_RANGE;
        endcase
        rs.len = shadow_len[LEN_W-1:0];
        case (rs.status)
            ST_DONE:  n_done++;
            ST_FULL:  n_full++;
            default:  n_range++;
        endcase
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // mostly in range, sometimes at or just past the end, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_pos(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (r == 1)
            return POS_W'(span);
        if (r == 2)
            return POS_W'(span + 1);
        if (span == 0)
            return '0;
        return POS_W'($urandom_range(0, span - 1));
    endfunction

    task automatic push_req(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] value);
        list_req_t rq;
        rq.func  = func;
        rq.pos   = pos;
        rq.value = value;
        @(negedge aclk);
        while (request_q.size() >= 2)
            @(negedge aclk);
        request_q.push_back(rq);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || reply_q.size() != 0)
            @(negedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin : drive_req
        list_req_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                nxt = request_q.pop_front();
                s_tdata  <= {{S_PAD_W{1'b0}}, nxt.value, nxt.pos, nxt.func};
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // reply back-pressure: rotating pattern, reloaded whenever the 8-bit age counter wraps
    always @(posedge aclk) begin : pace_reply
        logic [15:0] nxt_pat;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_pat <= '1;
            pat_age   <= '0;
        end else begin
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       nxt_pat = '1;
                    1:       nxt_pat = 16'($urandom) | 16'h0001;
                    2:       nxt_pat = 16'($urandom & $urandom) | 16'h0001;
                    default: nxt_pat = 16'h0001;
                endcase
            end else begin
                nxt_pat = {ready_pat[14:0], ready_pat[15]};
            end
            ready_pat <= nxt_pat;
            m_tready  <= nxt_pat[0];
            pat_age   <= pat_age + 8'd1;
        end
    end

    // reply checker and request predictor
    always @(posedge aclk) begin : watch
        list_req_t   seen;
        list_reply_t got;
        list_reply_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rd     = m_tdata[VALUE_W-1:0];
                got.status = m_tdata[VALUE_W +: STATUS_W];
                got.len    = m_tdata[VALUE_W+STATUS_W +: LEN_W];
                n_replies++;
                if (reply_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected reply word %h at cycle %0d", m_tdata, cycle_cnt);
                end else begin
                    want = reply_q.pop_front();
                    if (got.rd !== want.rd || got.status !== want.status
                            || got.len !== want.len) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("reply %0d mismatch: expected rd=%h st=%0d len=%0d, ",
                                     n_replies, want.rd, want.status, want.len,
                                     "got rd=%h st=%0d len=%0d",
                                     got.rd, got.status, got.len);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                seen.func  = s_tdata[FUNC_W-1:0];
                seen.pos   = s_tdata[FUNC_W +: POS_W];
                seen.value = s_tdata[FUNC_W+POS_W +: VALUE_W];
                apply_list_request(seen, want);
                reply_q.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_cnt, reply_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        mix_mode_t         mode;
        int unsigned       roll;
        int unsigned       ins_cut;
        int unsigned       del_cut;
        int unsigned       rd_cut;
        int unsigned       phase_left;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        logic [VALUE_W-1:0] v;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty-list misses, insert past the end
        push_req(OP_READ,   0, 32'h0000_0000);
        push_req(OP_DELETE, 0, 32'hFFFF_FFFF);
        push_req(OP_AT,     1, 32'h1234_5678);
        // build four elements with extreme values
        push_req(OP_HEAD,   0, 32'h7FFF_FFFF);
        push_req(OP_TAIL,   0, 32'h8000_0000);
        push_req(OP_AT,     1, 32'h0000_0000);
        push_req(OP_AT,     3, 32'hFFFF_FFFF);
        push_req(OP_AT,     5, 32'h0000_0005);
        for (int i = 0; i < 5; i++)
            push_req(OP_READ, POS_W'(i), 32'h0);
        push_req(OP_READ, 127, 32'h0);
        for (int i = OP_SPARE_LO; i <= FUNC_LAST; i++)
            push_req(FUNC_W'(i), 127, 32'hDEAD_BEEF);
        push_req(OP_DELETE, 127, 32'h0);
        push_req(OP_DELETE, 3,   32'h0);
        push_req(OP_DELETE, 0,   32'h0);
        push_req(OP_DELETE, 1,   32'h0);
        // sole element goes, list is empty again
        push_req(OP_DELETE, 0,   32'h0);
        push_req(OP_READ,   0,   32'h0);
        push_req(OP_HEAD,   0,   32'h5555_5555);

        wait_drained();

        phase_left = 0;
        mode = MODE_FILL;
        while (n_queued < ITEM_TARGET) begin
            if (phase_left == 0) begin
                mode = mix_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            if (n_queued % DRAIN_EVERY == 0)
                wait_drained();

            case (mode)
                MODE_FILL:  begin ins_cut = 70; del_cut = 80; rd_cut = 96; end
                MODE_DRAIN: begin ins_cut = 15; del_cut = 70; rd_cut = 96; end
                default:    begin ins_cut = 35; del_cut = 65; rd_cut = 96; end
            endcase

            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                default: v = $urandom;
            endcase
            p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            if (roll < ins_cut) begin
                case ($urandom_range(0, 2))
                    0:       f = OP_HEAD;
                    1:       f = OP_TAIL;
                    default: begin
                        f = OP_AT;
                        p = pick_pos(shadow_len + 1);
                    end
                endcase
            end else if (roll < del_cut) begin
                f = OP_DELETE;
                p = pick_pos(shadow_len);
            end else if (roll < rd_cut) begin
                f = OP_READ;
                p = pick_pos(shadow_len);
            end else begin
                f = FUNC_W'($urandom_range(OP_SPARE_LO, FUNC_LAST));
            end
            push_req(f, p, v);
        end

        wait_drained();
        repeat (END_CUSHION) @(posedge aclk);

        $display("%0d requests sent, %0d replies checked in %0d cycles",
                 n_queued, n_replies, cycle_cnt);
        $display("outcomes: %0d done, %0d out of range, %0d list full; ",
                 n_done, n_range, n_full,
                 "deepest list %0d of %0d", peak_len, CAPACITY_DEF);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
